// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the hex-float text formatter.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define AST_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define AST_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/b2hf_pkg.sv
// Package for the binary32 hex-float text formatter: types, ASCII codes
// and small helper functions. Depends on nothing.
package b2hf_pkg;

    localparam int FRAC_W = 23;
    localparam int EXPF_W = 8;
    localparam int SEXP_W = 9;

    localparam logic [EXPF_W-1:0] EXPF_SPECIAL = 8'hff;
    localparam logic signed [SEXP_W-1:0] EXP_BIAS = 9'sd127;
    localparam logic signed [SEXP_W-1:0] SUBN_EXP = -9'sd126;

    // ASCII codes
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LI    = 8'h69;
    localparam logic [7:0] CH_LN    = 8'h6e;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        CLS_NUM,
        CLS_ZERO,
        CLS_INF,
        CLS_NAN
    } cls_t;

    // Text fields walked by the character sequencer
    typedef enum logic [3:0] {
        F_SIGN,
        F_ZERO0,
        F_X,
        F_LEAD,
        F_DOT,
        F_DIG,
        F_P,
        F_ESIGN,
        F_EHUN,
        F_ETEN,
        F_EONE,
        F_SPEC0,
        F_SPEC1,
        F_SPEC2
    } fld_t;

    typedef struct packed {
        logic                      done;
        logic [FRAC_W-1:0]         frac;
        logic signed [SEXP_W-1:0]  expo;
    } norm_stat_t;

    typedef struct packed {
        logic                      sign;
        cls_t                      cls;
        logic [FRAC_W-1:0]         frac;
        logic signed [SEXP_W-1:0]  expo;
    } emit_cmd_t;

    // Lower-case hex character of one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = CH_0 + {4'b0000, nib};
        else
            c = CH_LA + {4'b0000, nib} - 8'd10;
        return c;
    endfunction

    // Number of fraction digits left after trimming trailing zero nibbles
    function automatic logic [2:0] frac_digits(input logic [23:0] f24);
        logic [2:0] n;
        if (f24[3:0] != 4'h0)
            n = 3'd6;
        else if (f24[7:4] != 4'h0)
            n = 3'd5;
        else if (f24[11:8] != 4'h0)
            n = 3'd4;
        else if (f24[15:12] != 4'h0)
            n = 3'd3;
        else if (f24[19:16] != 4'h0)
            n = 3'd2;
        else if (f24[23:20] != 4'h0)
            n = 3'd1;
        else
            n = 3'd0;
        return n;
    endfunction

    // Tens digit of a value below 100, by counting decade thresholds
    function automatic logic [3:0] dec_tens(input logic [6:0] v);
        logic [3:0] t;
        t = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= 7'(10 * k))
                t = t + 4'd1;
        end
        return t;
    endfunction

endpackage

// File: rtl/b2hf_norm.sv
// Iterative normalizer: one-bit left shift with exponent decrement per step.
// Depends on b2hf_pkg.
module b2hf_norm
    import b2hf_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic        step,
    input  logic [31:0] float_bits,
    output norm_stat_t  stat
);

    logic [FRAC_W:0]          mant_reg, mant_next;
    logic signed [SEXP_W-1:0] expo_reg, expo_next;

    logic [EXPF_W-1:0] expf;
    logic [FRAC_W-1:0] frac;

    assign expf = float_bits[30:23];
    assign frac = float_bits[22:0];

    // Load the mantissa, or shift one bit toward the hidden-bit position
    always_comb
    begin
        mant_next = mant_reg;
        expo_next = expo_reg;
        if (load)
        begin
            if (expf == '0 && frac != '0)
            begin
                mant_next = {1'b0, frac};
                expo_next = SUBN_EXP;
            end
            else
            begin
                mant_next = {1'b1, frac};
                expo_next = $signed({1'b0, expf}) - EXP_BIAS;
            end
        end
        else if (step)
        begin
            mant_next = {mant_reg[FRAC_W-1:0], 1'b0};
            expo_next = expo_reg - 9'sd1;
        end
    end

    always_ff @(posedge clk)
    begin
        mant_reg <= mant_next;
        expo_reg <= expo_next;
    end

    assign stat.done = mant_reg[FRAC_W];
    assign stat.frac = mant_reg[FRAC_W-1:0];
    assign stat.expo = expo_reg;

endmodule

// File: rtl/b2hf_emit.sv
// Character sequencer: walks the text fields and emits one ASCII word a cycle.
// Depends on b2hf_pkg.
module b2hf_emit
    import b2hf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  emit_cmd_t  cmd,
    output logic       char_valid,
    output logic [7:0] char_code,
    output logic       last_char
);

    logic        active_reg, active_next;
    fld_t        fld_reg, fld_next;
    logic        nan_reg, nan_next;
    logic        lead_one_reg, lead_one_next;
    logic [23:0] digits_reg, digits_next;
    logic [2:0]  ndig_reg, ndig_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [7:0]  mag_reg, mag_next;
    logic        eneg_reg, eneg_next;

    logic        is_spec;
    logic [23:0] f24_l;
    logic [3:0]  tens;
    fld_t        after_sign;
    fld_t        after_esign;

    assign is_spec = cmd.cls inside {CLS_INF, CLS_NAN};
    assign f24_l   = {cmd.frac, 1'b0};
    assign tens    = dec_tens(mag_reg[6:0]);

    assign after_sign  = nan_reg || !lead_one_reg && (ndig_reg == 3'd7) ? F_SPEC0 : F_ZERO0;
    assign after_esign = (mag_reg >= 8'd100) ? F_EHUN :
                         (mag_reg >= 8'd10)  ? F_ETEN : F_EONE;

    // Emit the current field and pick the next one
    always_comb
    begin
        active_next   = active_reg;
        fld_next      = fld_reg;
        nan_next      = nan_reg;
        lead_one_next = lead_one_reg;
        digits_next   = digits_reg;
        ndig_next     = ndig_reg;
        dcnt_next     = dcnt_reg;
        mag_next      = mag_reg;
        eneg_next     = eneg_reg;
        char_code     = CH_0;
        last_char     = 1'b0;

        case (fld_reg)
            F_SIGN:
            begin
                char_code = CH_MINUS;
                fld_next  = after_sign;
            end
            F_ZERO0:
            begin
                char_code = CH_0;
                fld_next  = F_X;
            end
            F_X:
            begin
                char_code = CH_LX;
                fld_next  = F_LEAD;
            end
            F_LEAD:
            begin
                char_code = lead_one_reg ? CH_1 : CH_0;
                fld_next  = (ndig_reg != 3'd0) ? F_DOT : F_P;
            end
            F_DOT:
            begin
                char_code = CH_DOT;
                fld_next  = F_DIG;
            end
            F_DIG:
            begin
                char_code   = hex_char(digits_reg[23:20]);
                digits_next = {digits_reg[19:0], 4'h0};
                dcnt_next   = dcnt_reg + 3'd1;
                if (dcnt_reg == ndig_reg - 3'd1)
                    fld_next = F_P;
            end
            F_P:
            begin
                char_code = CH_LP;
                fld_next  = F_ESIGN;
            end
            F_ESIGN:
            begin
                char_code = eneg_reg ? CH_MINUS : CH_PLUS;
                fld_next  = after_esign;
            end
            F_EHUN:
            begin
                char_code = CH_1;
                mag_next  = mag_reg - 8'd100;
                fld_next  = F_ETEN;
            end
            F_ETEN:
            begin
                char_code = CH_0 + {4'b0000, tens};
                mag_next  = mag_reg - ({4'b0000, tens} * 8'd10);
                fld_next  = F_EONE;
            end
            F_EONE:
            begin
                char_code   = CH_0 + {4'b0000, mag_reg[3:0]};
                last_char   = 1'b1;
                active_next = 1'b0;
            end
            F_SPEC0:
            begin
                char_code = nan_reg ? CH_LN : CH_LI;
                fld_next  = F_SPEC1;
            end
            F_SPEC1:
            begin
                char_code = nan_reg ? CH_LA : CH_LN;
                fld_next  = F_SPEC2;
            end
            F_SPEC2:
            begin
                char_code   = nan_reg ? CH_LN : CH_LF;
                last_char   = 1'b1;
                active_next = 1'b0;
            end
            default:
            begin
                char_code   = CH_0;
                active_next = 1'b0;
            end
        endcase

        // Hold everything while idle
        if (!active_reg)
        begin
            active_next   = active_reg;
            fld_next      = fld_reg;
            digits_next   = digits_reg;
            dcnt_next     = dcnt_reg;
            mag_next      = mag_reg;
            last_char     = 1'b0;
        end

        // Load a new value; special values reuse ndig as a marker for inf
        if (load)
        begin
            active_next   = 1'b1;
            nan_next      = (cmd.cls == CLS_NAN);
            lead_one_next = (cmd.cls == CLS_NUM);
            digits_next   = f24_l;
            dcnt_next     = 3'd0;
            if (is_spec)
                ndig_next = (cmd.cls == CLS_INF) ? 3'd7 : 3'd0;
            else if (cmd.cls == CLS_ZERO)
                ndig_next = 3'd0;
            else
                ndig_next = frac_digits(f24_l);
            if (cmd.cls == CLS_NUM)
            begin
                eneg_next = cmd.expo[SEXP_W-1];
                mag_next  = cmd.expo[SEXP_W-1] ? 8'(-cmd.expo) : 8'(cmd.expo);
            end
            else
            begin
                eneg_next = 1'b0;
                mag_next  = 8'd0;
            end
            if (cmd.sign)
                fld_next = F_SIGN;
            else if (is_spec)
                fld_next = F_SPEC0;
            else
                fld_next = F_ZERO0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            fld_reg    <= F_SIGN;
        end
        else
        begin
            active_reg <= active_next;
            fld_reg    <= fld_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        nan_reg      <= nan_next;
        lead_one_reg <= lead_one_next;
        digits_reg   <= digits_next;
        ndig_reg     <= ndig_next;
        dcnt_reg     <= dcnt_next;
        mag_reg      <= mag_next;
        eneg_reg     <= eneg_next;
    end

    assign char_valid = active_reg;

endmodule

// File: rtl/binary32_to_hex_float_text.sv
// Top level of the binary32 hex-float text formatter: control sequencer,
// normalizer and character sequencer. Depends on b2hf_pkg, b2hf_norm, b2hf_emit.
//
// Channel   Direction  Handshake                    Payload
// input     in         start & !busy accepts        float_bits[31:0]
// result    out        char_valid strobe, 1 cycle   char_code[7:0], last_char
//
// An accepted value is loaded into the normalizer, which shifts a subnormal
// left until its hidden bit is set (up to 23 shifts, none for other values);
// then n characters (3 to 16) are emitted on consecutive cycles, one per cycle.
// busy rises after the accept and stays high through the last character; the
// next value can be accepted the cycle after it.
// Reset clears the sequencers; nothing else is reset.
// The receiver cannot stall: each character is valid for exactly one cycle.
`include "assert_macros.svh"

module binary32_to_hex_float_text
    import b2hf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] float_bits,
    output logic        char_valid,
    output logic [7:0]  char_code,
    output logic        last_char
);

    ctl_state_t state_reg, state_next;
    logic       sign_reg, sign_next;
    cls_t       cls_reg, cls_next;

    logic       accept;
    cls_t       cls_in;
    norm_stat_t nstat;
    emit_cmd_t  ecmd;
    logic       norm_step;
    logic       emit_load;

    assign accept = start && (state_reg == ST_IDLE);

    // Classify the incoming word
    always_comb
    begin
        if (float_bits[30:0] == '0)
            cls_in = CLS_ZERO;
        else if (float_bits[30:23] == EXPF_SPECIAL)
            cls_in = (float_bits[22:0] == '0) ? CLS_INF : CLS_NAN;
        else
            cls_in = CLS_NUM;
    end

    // Sequence: normalize, then emit
    always_comb
    begin
        state_next = state_reg;
        sign_next  = sign_reg;
        cls_next   = cls_reg;
        norm_step  = 1'b0;
        emit_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sign_next  = float_bits[31];
                    cls_next   = cls_in;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (nstat.done)
                begin
                    emit_load  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    norm_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (char_valid && last_char)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        cls_reg  <= cls_next;
    end

    b2hf_norm u_norm (
        .clk        (clk),
        .load       (accept),
        .step       (norm_step),
        .float_bits (float_bits),
        .stat       (nstat)
    );

    assign ecmd.sign = sign_reg;
    assign ecmd.cls  = cls_reg;
    assign ecmd.frac = nstat.frac;
    assign ecmd.expo = nstat.expo;

    b2hf_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit_load),
        .cmd        (ecmd),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    assign busy = (state_reg != ST_IDLE);

    `AST_ALWAYS(a_valid_busy, char_valid |-> busy, "character word outside a busy period")
    `AST_CLK(a_accept_quiet, (start && !busy) |=> (busy && !char_valid), "accept did not start normalization")
    `AST_CLK(a_last_ends, (char_valid && last_char) |=> !char_valid, "word after the last character")
    `AST_CLK(a_text_contig, (char_valid && !last_char) |=> char_valid, "gap inside a text")

endmodule

// File: verif/tb_binary32_to_hex_float_text.sv
// Self-checking testbench for binary32_to_hex_float_text: drives float words,
// predicts the hex-float text of each one and checks every character strobe.
// Depends on b2hf_pkg and the RTL of binary32_to_hex_float_text.
`timescale 1ns / 1ps

module tb_binary32_to_hex_float_text;
    import b2hf_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_WORDS = 300;
    localparam int DRAIN_CYCLES = 50;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] float_bits = 32'h0000_0000;
    logic        busy;
    logic        char_valid;
    logic [7:0]  char_code;
    logic        last_char;

    logic [31:0] pending_words[$];
    text_char_t  expected_text[$];
    logic        word_taken = 1'b0;
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    binary32_to_hex_float_text DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .float_bits (float_bits),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Append the text of one float word to the expected characters
    function automatic void predict_text(input logic [31:0] bits);
        logic [7:0]  txt [0:15];
        logic [7:0]  expf;
        logic [23:0] mant;
        logic [23:0] f24;
        logic [3:0]  nib;
        int          n;
        int          e;
        int          mag;
        int          ndig;
        text_char_t  c;
        n = 0;
        expf = bits[30:23];
        mant = {1'b0, bits[22:0]};
        if (bits[31])
        begin
            txt[n] = CH_MINUS;
            n++;
        end
        if (bits[30:0] == 31'd0)
        begin
            txt[n] = "0";
            txt[n + 1] = "x";
            txt[n + 2] = "0";
            txt[n + 3] = "p";
            txt[n + 4] = "+";
            txt[n + 5] = "0";
            n += 6;
        end
        else if (expf == EXPF_SPECIAL)
        begin
            if (mant == 24'd0)
            begin
                txt[n] = "i";
                txt[n + 1] = "n";
                txt[n + 2] = "f";
            end
            else
            begin
                txt[n] = "n";
                txt[n + 1] = "a";
                txt[n + 2] = "n";
            end
            n += 3;
        end
        else
        begin
            // Normalize subnormals until the hidden bit is set
            if (expf == 8'd0)
            begin
                e = -126;
                while (!mant[23])
                begin
                    mant = mant << 1;
                    e--;
                end
            end
            else
                e = int'(expf) - 127;
            f24 = {mant[22:0], 1'b0};
            txt[n] = "0";
            txt[n + 1] = "x";
            txt[n + 2] = "1";
            n += 3;
            // Trim trailing zero digits of the fraction
            ndig = 6;
            while (ndig > 0 && f24[23 - 4 * (ndig - 1) -: 4] == 4'h0)
                ndig--;
            if (ndig > 0)
            begin
                txt[n] = ".";
                n++;
                for (int i = 0; i < ndig; i++)
                begin
                    nib = f24[23 - 4 * i -: 4];
                    txt[n] = (nib < 4'd10) ? 8'h30 + nib : 8'h61 + nib - 8'd10;
                    n++;
                end
            end
            txt[n] = "p";
            txt[n + 1] = (e >= 0) ? "+" : "-";
            n += 2;
            mag = (e >= 0) ? e : -e;
            if (mag >= 100)
            begin
                txt[n] = 8'h30 + 8'(mag / 100);
                n++;
            end
            if (mag >= 10)
            begin
                txt[n] = 8'h30 + 8'((mag / 10) % 10);
                n++;
            end
            txt[n] = 8'h30 + 8'(mag % 10);
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            c.code = txt[i];
            c.last = (i == n - 1);
            expected_text.push_back(c);
        end
    endfunction

    // Pick a random float word, weighted toward the interesting classes
    function automatic logic [31:0] random_float();
        logic        sgn;
        logic [22:0] frac;
        logic [23:0] mask24;
        logic [7:0]  expf;
        int          k;
        sgn = 1'($urandom_range(0, 1));
        frac = 23'($urandom);
        expf = 8'($urandom);
        case ($urandom_range(0, 9))
            4, 5:
            begin
                // Subnormal with a random leading-one position
                k = $urandom_range(1, 23);
                frac = frac & 23'((1 << k) - 1);
                if (frac == 23'd0)
                    frac = 23'(1 << (k - 1));
                expf = 8'd0;
            end
            6:
            begin
                case ($urandom_range(0, 2))
                    0: frac = 23'd0;
                    1:
                    begin
                        frac = 23'd0;
                        expf = EXPF_SPECIAL;
                    end
                    default:
                    begin
                        if (frac == 23'd0)
                            frac = 23'd1;
                        expf = EXPF_SPECIAL;
                    end
                endcase
                if (frac == 23'd0 && expf != EXPF_SPECIAL)
                    expf = 8'd0;
            end
            7:
            begin
                case ($urandom_range(0, 4))
                    0: expf = 8'd1;
                    1: expf = 8'd254;
                    2: expf = 8'd126;
                    3: expf = 8'd127;
                    default: expf = 8'd128;
                endcase
            end
            8:
            begin
                // Keep only the leading fraction digits
                k = $urandom_range(0, 6);
                mask24 = ~(24'hff_ffff >> (4 * k));
                frac = frac & mask24[23:1];
                if (expf == EXPF_SPECIAL)
                    expf = 8'd200;
            end
            9:
            begin
                frac = frac & 23'h00_000f;
                if (expf == EXPF_SPECIAL)
                    expf = 8'd3;
            end
            default:
            begin
                return $urandom;
            end
        endcase
        return {sgn, expf, frac};
    endfunction

    // Driver: feed pending words in bursts, hold each word until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !word_taken)
            ;
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            float_bits <= $urandom;
            gap_left--;
        end
        else if (pending_words.size() > 0)
        begin
            start <= 1'b1;
            float_bits <= pending_words.pop_front();
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            end
            else
                burst_left--;
        end
        else
            start <= 1'b0;
    end

    // Monitor: predict on each accepted word, check each character strobe
    always @(posedge clk)
    begin
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            word_taken <= start && !busy;
            if (char_valid)
            begin
                if (expected_text.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected char: code=%h last=%b", char_code, last_char);
                end
                else if (char_code !== expected_text[0].code
                         || last_char !== expected_text[0].last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("char mismatch: expected code=%h last=%b, got code=%h last=%b",
                                 expected_text[0].code, expected_text[0].last,
                                 char_code, last_char);
                    void'(expected_text.pop_front());
                end
                else
                    void'(expected_text.pop_front());
            end
            if (start && !busy)
                predict_text(float_bits);
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        // Directed words: zeros, specials, subnormals, extremes
        pending_words.push_back(32'h0000_0000);
        pending_words.push_back(32'h8000_0000);
        pending_words.push_back(32'h7f80_0000);
        pending_words.push_back(32'hff80_0000);
        pending_words.push_back(32'h7fc0_0000);
        pending_words.push_back(32'hffff_ffff);
        pending_words.push_back(32'h7f80_0001);
        pending_words.push_back(32'h0000_0001);
        pending_words.push_back(32'h8000_0001);
        pending_words.push_back(32'h007f_ffff);
        pending_words.push_back(32'h807f_ffff);
        pending_words.push_back(32'h0040_0000);
        pending_words.push_back(32'h0000_0003);
        pending_words.push_back(32'h0000_0400);
        pending_words.push_back(32'h0080_0000);
        pending_words.push_back(32'h3f80_0000);
        pending_words.push_back(32'hbf80_0000);
        pending_words.push_back(32'h3f80_0001);
        pending_words.push_back(32'h3fc0_0000);
        pending_words.push_back(32'h3f00_0000);
        pending_words.push_back(32'h4000_0000);
        pending_words.push_back(32'h42f6_0000);
        pending_words.push_back(32'h7f00_0000);
        pending_words.push_back(32'h7f7f_ffff);
        pending_words.push_back(32'hff7f_ffff);
        for (int i = 0; i < RANDOM_WORDS; i++)
            pending_words.push_back(random_float());

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all words taken, all characters seen, then a quiet tail
        while (pending_words.size() != 0 || start)
            @(posedge clk);
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: binary32_to_hex_float_text.f
+incdir+rtl
rtl/b2hf_pkg.sv
rtl/b2hf_norm.sv
rtl/b2hf_emit.sv
rtl/binary32_to_hex_float_text.sv
verif/tb_binary32_to_hex_float_text.sv
